[rtl/efs_pkg.sv]
package efs_pkg;

   localparam int MAX_SERVERS_DEFAULT = 16;

   localparam int ARRIVAL_W = 20;
   localparam int SERVICE_W = 8;
   localparam int SVC_CAP_W = 6;
   localparam int FREE_W    = 21;
   localparam int WAIT_W    = 20;
   localparam int COUNT_W   = 20;
   localparam int SUM_W     = 32;
   localparam int CSR_W     = 5;
   localparam int SRV_IDX_W = 4;

   localparam logic [SERVICE_W-1:0] SERVICE_CAP = 8'd60;
   localparam logic [FREE_W-1:0]    FREE_MAX    = '1;
   localparam logic [WAIT_W-1:0]    WAIT_MAX    = '1;
   localparam logic [COUNT_W-1:0]   COUNT_MAX   = '1;
   localparam logic [SUM_W-1:0]     SUM_MAX     = '1;
   localparam logic [CSR_W-1:0]     CSR_RESET   = 5'd1;

endpackage

[rtl/efs_store.sv]
module efs_store #(
   parameter int MAX_SERVERS = efs_pkg::MAX_SERVERS_DEFAULT,
   parameter int IDX_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [IDX_W-1:0]            rd_addr,
   output logic [efs_pkg::FREE_W-1:0]  rd_free,
   output logic [efs_pkg::COUNT_W-1:0] rd_served,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_addr,
   input  logic [efs_pkg::FREE_W-1:0]  wr_free,
   input  logic [efs_pkg::COUNT_W-1:0] wr_served
);

   logic [efs_pkg::FREE_W-1:0]  free_mem   [MAX_SERVERS];
   logic [efs_pkg::COUNT_W-1:0] served_mem [MAX_SERVERS];
   logic [MAX_SERVERS-1:0]      vld_ff;
   logic [efs_pkg::FREE_W-1:0]  rd_free_ff;
   logic [efs_pkg::COUNT_W-1:0] rd_served_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         free_mem[wr_addr]   <= wr_free;
         served_mem[wr_addr] <= wr_served;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_free_ff   <= vld_ff[rd_addr] ? free_mem[rd_addr] : '0;
         rd_served_ff <= vld_ff[rd_addr] ? served_mem[rd_addr] : '0;
      end
   end

   assign rd_free   = rd_free_ff;
   assign rd_served = rd_served_ff;

endmodule

[rtl/efs_engine.sv]
module efs_engine #(
   parameter int MAX_SERVERS = efs_pkg::MAX_SERVERS_DEFAULT,
   parameter int IDX_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1,
   parameter int CNT_W       = $clog2(MAX_SERVERS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [efs_pkg::ARRIVAL_W-1:0] req_arrival_time,
   input  logic [efs_pkg::SERVICE_W-1:0] req_service_time,
   input  logic [CNT_W-1:0]              open_cnt,
   output logic                          rd_en,
   output logic [IDX_W-1:0]              rd_addr,
   input  logic [efs_pkg::FREE_W-1:0]    rd_free,
   input  logic [efs_pkg::COUNT_W-1:0]   rd_served,
   output logic                          wr_en,
   output logic [IDX_W-1:0]              wr_addr,
   output logic [efs_pkg::FREE_W-1:0]    wr_free,
   output logic [efs_pkg::COUNT_W-1:0]   wr_served,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [efs_pkg::SRV_IDX_W-1:0] rsp_server_index,
   output logic [efs_pkg::WAIT_W-1:0]    rsp_job_wait,
   output logic [efs_pkg::SUM_W-1:0]     rsp_total_wait,
   output logic [efs_pkg::WAIT_W-1:0]    rsp_max_wait,
   output logic [efs_pkg::FREE_W-1:0]    rsp_latest_finish,
   output logic [efs_pkg::COUNT_W-1:0]   rsp_server_served
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PICK,
      ST_UPDATE
   } state_type;

   state_type                     state_ff, state_in;
   logic [efs_pkg::ARRIVAL_W-1:0] arr_ff, arr_in;
   logic [efs_pkg::SVC_CAP_W-1:0] svc_ff, svc_in;
   logic [CNT_W-1:0]              n_ff, n_in;
   logic [CNT_W-1:0]              iss_ff, iss_in;
   logic                          chk_vld_ff, chk_vld_in;
   logic [CNT_W-1:0]              chk_idx_ff, chk_idx_in;
   logic                          found_ff, found_in;
   logic [IDX_W-1:0]              hit_idx_ff, hit_idx_in;
   logic [efs_pkg::FREE_W-1:0]    best_ff, best_in;
   logic [IDX_W-1:0]              best_idx_ff, best_idx_in;
   logic [efs_pkg::FREE_W-1:0]    latest_ff, latest_in;
   logic [IDX_W-1:0]              pick_ff, pick_in;
   logic [efs_pkg::FREE_W-1:0]    new_free_ff, new_free_in;
   logic [efs_pkg::WAIT_W-1:0]    wait_ff, wait_in;
   logic [efs_pkg::SUM_W-1:0]     sum_ff, sum_in;
   logic [efs_pkg::WAIT_W-1:0]    peak_ff, peak_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [efs_pkg::SRV_IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [efs_pkg::WAIT_W-1:0]    rsp_wait_ff, rsp_wait_in;
   logic [efs_pkg::SUM_W-1:0]     rsp_sum_ff, rsp_sum_in;
   logic [efs_pkg::WAIT_W-1:0]    rsp_peak_ff, rsp_peak_in;
   logic [efs_pkg::FREE_W-1:0]    rsp_latest_ff, rsp_latest_in;
   logic [efs_pkg::COUNT_W-1:0]   rsp_served_ff, rsp_served_in;

   logic                          accept;
   logic                          fire;
   logic [efs_pkg::FREE_W-1:0]    arr_ext;
   logic [IDX_W-1:0]              sel_idx;
   logic [efs_pkg::FREE_W-1:0]    base;
   logic [efs_pkg::FREE_W:0]      end_sum;
   logic [efs_pkg::FREE_W-1:0]    diff;
   logic [efs_pkg::COUNT_W-1:0]   served_new;
   logic [efs_pkg::SUM_W:0]       wsum;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign fire      = (state_ff == ST_UPDATE) && (!rsp_valid_ff || !rsp_stall);
   assign arr_ext   = efs_pkg::FREE_W'(arr_ff);

   assign sel_idx = found_ff ? hit_idx_ff : best_idx_ff;
   assign base    = found_ff ? arr_ext : best_ff;
   assign end_sum = {1'b0, base} + (efs_pkg::FREE_W + 1)'(svc_ff);
   assign diff    = best_ff - arr_ext;

   assign served_new = (rd_served == efs_pkg::COUNT_MAX) ? rd_served
                                                         : rd_served + 1'b1;
   assign wsum       = {1'b0, sum_ff} + (efs_pkg::SUM_W + 1)'(wait_ff);

   assign rd_en   = ((state_ff == ST_SCAN) && (iss_ff < n_ff)) || (state_ff == ST_PICK);
   assign rd_addr = (state_ff == ST_PICK) ? sel_idx : iss_ff[IDX_W-1:0];

   assign wr_en     = fire;
   assign wr_addr   = pick_ff;
   assign wr_free   = new_free_ff;
   assign wr_served = served_new;

   always_comb begin
      state_in      = state_ff;
      arr_in        = arr_ff;
      svc_in        = svc_ff;
      n_in          = n_ff;
      iss_in        = iss_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = iss_ff;
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      latest_in     = latest_ff;
      pick_in       = pick_ff;
      new_free_in   = new_free_ff;
      wait_in       = wait_ff;
      sum_in        = sum_ff;
      peak_in       = peak_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_idx_in    = rsp_idx_ff;
      rsp_wait_in   = rsp_wait_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_peak_in   = rsp_peak_ff;
      rsp_latest_in = rsp_latest_ff;
      rsp_served_in = rsp_served_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               arr_in    = req_arrival_time;
               svc_in    = (req_service_time > efs_pkg::SERVICE_CAP)
                           ? efs_pkg::SVC_CAP_W'(efs_pkg::SERVICE_CAP)
                           : req_service_time[efs_pkg::SVC_CAP_W-1:0];
               n_in      = open_cnt;
               iss_in    = '0;
               found_in  = 1'b0;
               latest_in = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (iss_ff < n_ff) begin
               chk_vld_in = 1'b1;
               iss_in     = iss_ff + 1'b1;
            end
            if (chk_vld_ff) begin
               if (!found_ff && (arr_ext >= rd_free)) begin
                  found_in   = 1'b1;
                  hit_idx_in = chk_idx_ff[IDX_W-1:0];
               end
               if ((chk_idx_ff == '0) || (rd_free < best_ff)) begin
                  best_in     = rd_free;
                  best_idx_in = chk_idx_ff[IDX_W-1:0];
               end
               if (rd_free > latest_ff) begin
                  latest_in = rd_free;
               end
               if (CNT_W'(chk_idx_ff + 1'b1) == n_ff) begin
                  state_in = ST_PICK;
               end
            end
         end
         ST_PICK: begin
            pick_in     = sel_idx;
            new_free_in = end_sum[efs_pkg::FREE_W] ? efs_pkg::FREE_MAX
                                                   : end_sum[efs_pkg::FREE_W-1:0];
            if (found_ff) begin
               wait_in = '0;
            end else if (diff > efs_pkg::FREE_W'(efs_pkg::WAIT_MAX)) begin
               wait_in = efs_pkg::WAIT_MAX;
            end else begin
               wait_in = diff[efs_pkg::WAIT_W-1:0];
            end
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (fire) begin
               sum_in        = wsum[efs_pkg::SUM_W] ? efs_pkg::SUM_MAX
                                                    : wsum[efs_pkg::SUM_W-1:0];
               peak_in       = (wait_ff > peak_ff) ? wait_ff : peak_ff;
               rsp_valid_in  = 1'b1;
               rsp_idx_in    = efs_pkg::SRV_IDX_W'(pick_ff);
               rsp_wait_in   = wait_ff;
               rsp_sum_in    = sum_in;
               rsp_peak_in   = peak_in;
               rsp_latest_in = (new_free_ff > latest_ff) ? new_free_ff : latest_ff;
               rsp_served_in = served_new;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         sum_ff       <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         found_ff     <= found_in;
         sum_ff       <= sum_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      arr_ff        <= arr_in;
      svc_ff        <= svc_in;
      n_ff          <= n_in;
      iss_ff        <= iss_in;
      chk_idx_ff    <= chk_idx_in;
      hit_idx_ff    <= hit_idx_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      latest_ff     <= latest_in;
      pick_ff       <= pick_in;
      new_free_ff   <= new_free_in;
      wait_ff       <= wait_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_wait_ff   <= rsp_wait_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_peak_ff   <= rsp_peak_in;
      rsp_latest_ff <= rsp_latest_in;
      rsp_served_ff <= rsp_served_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_server_index  = rsp_idx_ff;
   assign rsp_job_wait      = rsp_wait_ff;
   assign rsp_total_wait    = rsp_sum_ff;
   assign rsp_max_wait      = rsp_peak_ff;
   assign rsp_latest_finish = rsp_latest_ff;
   assign rsp_server_served = rsp_served_ff;

endmodule

[rtl/earliest_free_server_dispatch_unit.sv]
// Job dispatcher for one queue served by up to MAX_SERVERS windows.
// req channel: one job per transfer (arrival tick, service time); the job
//   goes to the lowest free server or, if none is free, to the one that
//   frees up earliest.
// rsp channel: one result per job (server, wait, total and peak wait,
//   latest finish, served count of the chosen server).
// csr port: csr_wr_en writes the number of open windows; write it only
//   while no job is in flight.
// Flow: a job's result is shown after a scan of one read per open window
//   of the free-at memory and a read-modify-write of the chosen entry.
// Busy: one job at a time; req_stall stays high until the result is
//   loaded into the output register.
// Stall: a stalled result holds in the output register; the next job is
//   taken and scanned meanwhile and waits before write-back until the
//   register frees.
// Reset: clears all server entries, the wait statistics and the output
//   valid, and sets the window count to one.
module earliest_free_server_dispatch_unit #(
   parameter int MAX_SERVERS = efs_pkg::MAX_SERVERS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [efs_pkg::ARRIVAL_W-1:0] req_arrival_time,
   input  logic [efs_pkg::SERVICE_W-1:0] req_service_time,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [efs_pkg::SRV_IDX_W-1:0] rsp_server_index,
   output logic [efs_pkg::WAIT_W-1:0]    rsp_job_wait,
   output logic [efs_pkg::SUM_W-1:0]     rsp_total_wait,
   output logic [efs_pkg::WAIT_W-1:0]    rsp_max_wait,
   output logic [efs_pkg::FREE_W-1:0]    rsp_latest_finish,
   output logic [efs_pkg::COUNT_W-1:0]   rsp_server_served,
   input  logic                          csr_wr_en,
   input  logic [efs_pkg::CSR_W-1:0]     csr_wr_data
);

   localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int CNT_W = $clog2(MAX_SERVERS + 1);

   logic [efs_pkg::CSR_W-1:0]   active_ff, active_in;
   logic [CNT_W-1:0]            open_cnt;
   logic                        rd_en;
   logic [IDX_W-1:0]            rd_addr;
   logic [efs_pkg::FREE_W-1:0]  rd_free;
   logic [efs_pkg::COUNT_W-1:0] rd_served;
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   logic [efs_pkg::FREE_W-1:0]  wr_free;
   logic [efs_pkg::COUNT_W-1:0] wr_served;

   assign active_in = csr_wr_en ? csr_wr_data : active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= efs_pkg::CSR_RESET;
      end else begin
         active_ff <= active_in;
      end
   end

   always_comb begin
      if (active_ff == '0) begin
         open_cnt = CNT_W'(1);
      end else if (32'(active_ff) > 32'(MAX_SERVERS)) begin
         open_cnt = CNT_W'(MAX_SERVERS);
      end else begin
         open_cnt = CNT_W'(active_ff);
      end
   end

   efs_store #(
      .MAX_SERVERS (MAX_SERVERS),
      .IDX_W       (IDX_W)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_free   (rd_free),
      .rd_served (rd_served),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_free   (wr_free),
      .wr_served (wr_served)
   );

   efs_engine #(
      .MAX_SERVERS (MAX_SERVERS),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_arrival_time  (req_arrival_time),
      .req_service_time  (req_service_time),
      .open_cnt          (open_cnt),
      .rd_en             (rd_en),
      .rd_addr           (rd_addr),
      .rd_free           (rd_free),
      .rd_served         (rd_served),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_free           (wr_free),
      .wr_served         (wr_served),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_server_index  (rsp_server_index),
      .rsp_job_wait      (rsp_job_wait),
      .rsp_total_wait    (rsp_total_wait),
      .rsp_max_wait      (rsp_max_wait),
      .rsp_latest_finish (rsp_latest_finish),
      .rsp_server_served (rsp_server_served)
   );

`ifndef NO_ASSERTIONS
   a_peak_covers_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_job_wait <= rsp_max_wait)
      else $error("max wait below job wait");

   a_sum_covers_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_job_wait) <= rsp_total_wait)
      else $error("total wait below job wait");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("job transfer not followed by busy");

   a_served_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_server_served != '0)
      else $error("served count zero on result");
`endif

endmodule

[test/tb_top.sv]
module tb_top;

   localparam int NSRV        = efs_pkg::MAX_SERVERS_DEFAULT;
   localparam int QUIET_LIMIT = 4000;
   localparam int PHASE_JOBS  = 85;
   localparam int FLOOD_JOBS  = 60;

   typedef struct {
      logic [efs_pkg::ARRIVAL_W-1:0] arrival;
      logic [efs_pkg::SERVICE_W-1:0] service;
   } job_type;

   typedef struct {
      logic [efs_pkg::SRV_IDX_W-1:0] server;
      logic [efs_pkg::WAIT_W-1:0]    job_wait;
      logic [efs_pkg::SUM_W-1:0]     total_wait;
      logic [efs_pkg::WAIT_W-1:0]    max_wait;
      logic [efs_pkg::FREE_W-1:0]    latest_finish;
      logic [efs_pkg::COUNT_W-1:0]   served;
   } dispatch_type;

   logic                          clock;
   logic                          reset            = 1'b1;
   logic                          req_valid        = 1'b0;
   logic                          req_stall;
   logic [efs_pkg::ARRIVAL_W-1:0] req_arrival_time = '0;
   logic [efs_pkg::SERVICE_W-1:0] req_service_time = '0;
   logic                          rsp_valid;
   logic                          rsp_stall        = 1'b0;
   logic [efs_pkg::SRV_IDX_W-1:0] rsp_server_index;
   logic [efs_pkg::WAIT_W-1:0]    rsp_job_wait;
   logic [efs_pkg::SUM_W-1:0]     rsp_total_wait;
   logic [efs_pkg::WAIT_W-1:0]    rsp_max_wait;
   logic [efs_pkg::FREE_W-1:0]    rsp_latest_finish;
   logic [efs_pkg::COUNT_W-1:0]   rsp_server_served;
   logic                          csr_wr_en        = 1'b0;
   logic [efs_pkg::CSR_W-1:0]     csr_wr_data      = '0;

   job_type                     job_q[$];
   dispatch_type                dispatch_q[$];
   logic [efs_pkg::FREE_W-1:0]  free_at [NSRV];
   logic [efs_pkg::COUNT_W-1:0] served_cnt [NSRV];
   logic [efs_pkg::SUM_W-1:0]   wait_total;
   logic [efs_pkg::WAIT_W-1:0]  wait_peak;
   logic [efs_pkg::CSR_W-1:0]   window_cfg;
   logic                        req_fired    = 1'b0;
   int                          idle_pct     = 0;
   int                          stall_pct    = 0;
   int                          error_count  = 0;
   int                          quiet_cycles = 0;
   int                          arrival_now  = 0;

   earliest_free_server_dispatch_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_arrival_time  (req_arrival_time),
      .req_service_time  (req_service_time),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_server_index  (rsp_server_index),
      .rsp_job_wait      (rsp_job_wait),
      .rsp_total_wait    (rsp_total_wait),
      .rsp_max_wait      (rsp_max_wait),
      .rsp_latest_finish (rsp_latest_finish),
      .rsp_server_served (rsp_server_served),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic dispatch_type dispatch_job(job_type job);
      int unsigned                windows;
      int unsigned                pick;
      int unsigned                i;
      bit                         found;
      longint unsigned            svc;
      longint unsigned            best;
      longint unsigned            gap;
      longint unsigned            finish;
      longint unsigned            acc;
      logic [efs_pkg::FREE_W-1:0] latest;
      dispatch_type               r;
      windows = (window_cfg == 0) ? 1 : (window_cfg > NSRV) ? NSRV : window_cfg;
      svc = (job.service > efs_pkg::SERVICE_CAP) ? efs_pkg::SERVICE_CAP : job.service;
      found = 1'b0;
      pick = 0;
      r.job_wait = '0;
      for (i = 0; i < windows; i++) begin
         if (!found && job.arrival >= free_at[i]) begin
            found = 1'b1;
            pick = i;
         end
      end
      if (found) begin
         finish = job.arrival + svc;
      end else begin
         best = free_at[0];
         for (i = 1; i < windows; i++) begin
            if (free_at[i] < best) begin
               best = free_at[i];
               pick = i;
            end
         end
         gap = best - job.arrival;
         r.job_wait = (gap > efs_pkg::WAIT_MAX) ? efs_pkg::WAIT_MAX
                                                : efs_pkg::WAIT_W'(gap);
         finish = best + svc;
         acc = wait_total + r.job_wait;
         wait_total = (acc > efs_pkg::SUM_MAX) ? efs_pkg::SUM_MAX : efs_pkg::SUM_W'(acc);
         if (r.job_wait > wait_peak) wait_peak = r.job_wait;
      end
      free_at[pick] = (finish > efs_pkg::FREE_MAX) ? efs_pkg::FREE_MAX
                                                   : efs_pkg::FREE_W'(finish);
      if (served_cnt[pick] != efs_pkg::COUNT_MAX) begin
         served_cnt[pick] = served_cnt[pick] + 1'b1;
      end
      latest = '0;
      for (i = 0; i < windows; i++) begin
         if (free_at[i] > latest) latest = free_at[i];
      end
      r.server        = efs_pkg::SRV_IDX_W'(pick);
      r.total_wait    = wait_total;
      r.max_wait      = wait_peak;
      r.latest_finish = latest;
      r.served        = served_cnt[pick];
      return r;
   endfunction

   task automatic report_error(string msg);
      error_count++;
      if (error_count <= 100) $display("ERROR at %0t: %s", $time, msg);
   endtask

   task automatic compare_field(string name, longint unsigned got, longint unsigned want);
      if (got != want) report_error($sformatf("%s: got %0d, expected %0d", name, got, want));
   endtask

   always @(posedge clock) begin : monitor
      job_type      seen;
      dispatch_type want;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (dispatch_q.size() == 0) begin
               report_error("result transfer with no job outstanding");
            end else begin
               want = dispatch_q.pop_front();
               compare_field("server_index", rsp_server_index, want.server);
               compare_field("job_wait", rsp_job_wait, want.job_wait);
               compare_field("total_wait", rsp_total_wait, want.total_wait);
               compare_field("max_wait", rsp_max_wait, want.max_wait);
               compare_field("latest_finish", rsp_latest_finish, want.latest_finish);
               compare_field("server_served", rsp_server_served, want.served);
            end
         end
         if (req_valid && !req_stall) begin
            seen.arrival = req_arrival_time;
            seen.service = req_service_time;
            dispatch_q.push_back(dispatch_job(seen));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(negedge clock) begin : driver
      job_type job;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (job_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
            job = job_q.pop_front();
            req_valid        <= 1'b1;
            req_arrival_time <= job.arrival;
            req_service_time <= job.service;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   task automatic queue_job(int unsigned arrival, int unsigned service);
      job_type job;
      job.arrival = efs_pkg::ARRIVAL_W'(arrival);
      job.service = efs_pkg::SERVICE_W'(service);
      job_q.push_back(job);
   endtask

   task automatic queue_random_job();
      int unsigned windows;
      int unsigned arrival;
      int unsigned r;
      windows = (window_cfg == 0) ? 1 : (window_cfg > NSRV) ? NSRV : window_cfg;
      r = $urandom_range(99);
      if (r < 3) arrival_now += $urandom_range(60000, 1);
      else arrival_now += $urandom_range(12 * windows, 0);
      if (arrival_now > 1048575) arrival_now = 1048575;
      arrival = arrival_now;
      if ($urandom_range(99) < 2) begin
         arrival = (arrival_now > 500) ? arrival_now - $urandom_range(500, 1) : 0;
      end
      queue_job(arrival, ($urandom_range(99) < 70) ? $urandom_range(60, 0)
                                                   : $urandom_range(255, 0));
   endtask

   task automatic wait_idle();
      while (job_q.size() != 0 || req_valid || dispatch_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_windows(logic [efs_pkg::CSR_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      window_cfg = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      int plan [8]       = '{0, 16, 3, 31, 17, 7, 1, 12};
      int idle_plan [4]  = '{0, 69, 0, 27};
      int stall_plan [4] = '{0, 0, 69, 27};
      int i;
      int k;
      for (i = 0; i < NSRV; i++) begin
         free_at[i] = '0;
         served_cnt[i] = '0;
      end
      wait_total = '0;
      wait_peak  = '0;
      window_cfg = efs_pkg::CSR_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one window: free start, capped service, queued waits
      queue_job(0, 0);
      queue_job(0, 255);
      queue_job(10, 61);
      queue_job(10, 60);
      queue_job(200, 128);
      wait_idle();
      write_windows(5'd4);
      // fill four windows, then tie on the earliest free time
      for (i = 0; i < 4; i++) queue_job(300, 20);
      queue_job(300, 40);
      queue_job(305, 10);
      queue_job(330, 5);
      queue_job(1000, 0);
      queue_job(1000, 255);
      arrival_now = 1000;
      wait_idle();

      for (k = 0; k < 8; k++) begin
         write_windows(efs_pkg::CSR_W'(plan[k]));
         idle_pct  = idle_plan[k % 4];
         stall_pct = stall_plan[k % 4];
         for (i = 0; i < PHASE_JOBS; i++) queue_random_job();
         wait_idle();
      end

      // flood one window from the top arrival tick back to zero: drive the
      // wait into saturation
      write_windows(5'd1);
      idle_pct  = 0;
      stall_pct = 0;
      queue_job(20'hFFFFF, 60);
      for (i = 0; i < FLOOD_JOBS; i++) queue_job(0, $urandom_range(255, 61));
      wait_idle();
      write_windows(5'd16);
      idle_pct  = 27;
      stall_pct = 27;
      for (i = 0; i < 40; i++) begin
         queue_job($urandom_range(1048575, 0), $urandom_range(255, 0));
      end
      wait_idle();

      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[files.f]
rtl/efs_pkg.sv
rtl/efs_store.sv
rtl/efs_engine.sv
rtl/earliest_free_server_dispatch_unit.sv
test/tb_top.sv
